// ===== sv/bfa_pkg.sv =====
`default_nettype none
package bfa_pkg;

	// External field widths
	localparam int SIZE_W   = 21;
	localparam int OFF_W    = 20;
	localparam int STATUS_W = 3;

	// Reset value of the region size register
	localparam logic [SIZE_W-1:0] REGION_RESET = 21'd65536;

	// Request codes
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// Completion codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_FIT   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_BUSY = 3'd4;

endpackage
`default_nettype wire

// ===== sv/bfa_table_mem.sv =====
`default_nettype none
module bfa_table_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 41
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/best_fit_block_allocator.sv =====
// Sequence: a request rejected up front completes from idle; otherwise an empty table is
//   first set up, the table is scanned, then a failed lookup ends, or on success entries
//   are moved one by one and the write-back states S_WR1 and S_WR2 follow.
// Transactions: one at a time, limited by the single read and single write port of the
//   block table. Reset: asynchronous, the table is empty (the first allocation writes
//   one free block over the region) and region_size is 65536; results are strobed for
//   one cycle and cannot be stalled.
`default_nettype none
module best_fit_block_allocator #(
	parameter int MAX_BLOCKS   = 64,
	parameter int HEADER_BYTES = 8,
	parameter int OFFSET_BITS  = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bfa_pkg::SIZE_W-1:0]    cfg_data,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          action,
	input  wire logic [bfa_pkg::SIZE_W-1:0]    request_size,
	input  wire logic [bfa_pkg::OFF_W-1:0]     payload_offset,
	output logic                               done,
	output logic      [bfa_pkg::STATUS_W-1:0]  status,
	output logic      [bfa_pkg::OFF_W-1:0]     granted_offset
);

	localparam int OB   = OFFSET_BITS;
	localparam int IW   = $clog2(MAX_BLOCKS);
	localparam int CNTW = $clog2(MAX_BLOCKS + 1);
	localparam int DW   = 2 * OB + 1;
	localparam int CW   = ((OB > bfa_pkg::SIZE_W) ? OB : bfa_pkg::SIZE_W) + 2;
	localparam int OFFW = bfa_pkg::OFF_W;

	localparam logic [CW-1:0]   H_C   = CW'(HEADER_BYTES);
	localparam logic [CW-1:0]   LIM_C = CW'(1) << OB;
	localparam logic [CNTW-1:0] MAX_C = CNTW'(MAX_BLOCKS);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_MAT    = 9'b000000010,
		S_SCAN   = 9'b000000100,
		S_DECIDE = 9'b000001000,
		S_SH_RD  = 9'b000010000,
		S_SH_WR  = 9'b000100000,
		S_WR1    = 9'b001000000,
		S_WR2    = 9'b010000000,
		S_SPARE  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [bfa_pkg::SIZE_W-1:0] region_q;
	logic [CNTW-1:0]            count_q;
	logic [CNTW-1:0]            new_count_q;
	logic                       action_q;
	logic [CW-1:0]              rounded_q;
	logic [CW-1:0]              need_q;
	logic [CW-1:0]              target_q;

	// Scan
	logic [CNTW-1:0] issue_q;
	logic            pend_s1;
	logic [CNTW-1:0] idx_s1;
	logic            found_q;
	logic [CNTW-1:0] best_idx_q;
	logic [OB-1:0]   best_size_q;
	logic [OB-1:0]   best_start_q;
	logic            best_busy_q;
	logic [DW-1:0]   last_q;
	logic [DW-1:0]   prev_q;
	logic [DW-1:0]   next_q;
	logic            next_v_q;

	// Shift and write-back
	logic [CNTW-1:0] sh_dst_q;
	logic [CNTW-1:0] sh_lim_q;
	logic            sh_up_q;
	logic [1:0]      sh_n_q;
	logic            w1_v_q;
	logic [IW-1:0]   w1_a_q;
	logic [DW-1:0]   w1_d_q;
	logic            w2_v_q;
	logic [IW-1:0]   w2_a_q;
	logic [DW-1:0]   w2_d_q;

	logic                          done_q;
	logic [bfa_pkg::STATUS_W-1:0]  status_q;
	logic [OFFW-1:0]               granted_q;

	// Memory ports
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	logic [DW-1:0] mem_wd;
	logic          mem_re;
	logic [IW-1:0] mem_ra;
	logic [DW-1:0] mem_rd;

	bfa_table_mem #(
		.DEPTH(MAX_BLOCKS),
		.AW   (IW),
		.DW   (DW)
	) u_table (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_wa),
		.wr_data(mem_wd),
		.rd_en  (mem_re),
		.rd_addr(mem_ra),
		.rd_data(mem_rd)
	);

	// Entry fields of the returned read
	logic          rd_busy;
	logic [OB-1:0] rd_size;
	logic [OB-1:0] rd_start;
	assign rd_busy  = mem_rd[DW-1];
	assign rd_size  = mem_rd[2*OB-1:OB];
	assign rd_start = mem_rd[OB-1:0];

	// Initial free block payload
	logic [CW-1:0] reg_clamp;
	logic [OB-1:0] init_payload;
	always_comb begin
		reg_clamp = CW'(region_q);
		if (reg_clamp > LIM_C) begin
			reg_clamp = LIM_C;
		end
		if (reg_clamp < H_C) begin
			init_payload = '0;
		end else begin
			init_payload = OB'(reg_clamp - H_C);
		end
	end

	// Request decode
	logic [CW-1:0] req_round;
	logic [CW-1:0] off_ext;
	assign req_round = (CW'(request_size) + CW'(3)) & ~CW'(3);
	assign off_ext   = CW'(payload_offset);

	// Shift loop control
	logic          sh_go;
	logic [CNTW-1:0] sh_src;
	always_comb begin
		if (sh_up_q) begin
			sh_go  = sh_dst_q > sh_lim_q;
			sh_src = sh_dst_q - CNTW'(1);
		end else begin
			sh_go  = (sh_n_q != 2'd0) && ((sh_dst_q + CNTW'(sh_n_q)) < count_q);
			sh_src = sh_dst_q + CNTW'(sh_n_q);
		end
	end

	// Memory access selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = '0;
		case (state_q)
			S_MAT: begin
				mem_we = 1'b1;
				mem_wd = {1'b0, init_payload, OB'(0)};
			end
			S_SCAN: begin
				mem_re = issue_q < count_q;
				mem_ra = issue_q[IW-1:0];
			end
			S_SH_RD: begin
				mem_re = sh_go;
				mem_ra = sh_src[IW-1:0];
			end
			S_SH_WR: begin
				mem_we = 1'b1;
				mem_wa = sh_dst_q[IW-1:0];
				mem_wd = mem_rd;
			end
			S_WR1: begin
				mem_we = w1_v_q;
				mem_wa = w1_a_q;
				mem_wd = w1_d_q;
			end
			S_WR2: begin
				mem_we = w2_v_q;
				mem_wa = w2_a_q;
				mem_wd = w2_d_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Decision values
	logic          split;
	logic [OB-1:0] nstart;
	logic [OB-1:0] nsize;
	logic          right_m;
	logic          left_m;
	logic [OB-1:0] merged;
	logic [OB-1:0] left_sz;
	always_comb begin
		split   = ((CW'(best_size_q) - rounded_q) > H_C) && (count_q < MAX_C);
		nstart  = OB'(CW'(best_start_q) + need_q);
		nsize   = OB'(CW'(best_size_q) - need_q);
		right_m = next_v_q && !next_q[DW-1];
		left_m  = (best_idx_q != '0) && !prev_q[DW-1];
		merged  = right_m ? OB'(CW'(best_size_q) + H_C + CW'(next_q[2*OB-1:OB]))
		                  : best_size_q;
		left_sz = OB'(CW'(prev_q[2*OB-1:OB]) + H_C + CW'(merged));
	end

	assign cfg_ready      = 1'b1;
	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign granted_offset = granted_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			region_q  <= bfa_pkg::REGION_RESET;
			count_q   <= '0;
			done_q    <= 1'b0;
			status_q  <= bfa_pkg::ST_OK;
			granted_q <= '0;
			pend_s1   <= 1'b0;
			found_q   <= 1'b0;
			next_v_q  <= 1'b0;
			issue_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				region_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						action_q  <= action;
						rounded_q <= req_round;
						need_q    <= req_round + H_C;
						target_q  <= off_ext - H_C;
						issue_q   <= '0;
						pend_s1   <= 1'b0;
						found_q   <= 1'b0;
						next_v_q  <= 1'b0;
						granted_q <= '0;
						if (action == bfa_pkg::ACT_ALLOC) begin
							if (request_size == '0) begin
								status_q <= bfa_pkg::ST_BAD_SIZE;
								done_q   <= 1'b1;
							end else if (count_q == '0) begin
								state_q <= S_MAT;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							if (off_ext < H_C) begin
								status_q <= bfa_pkg::ST_BAD_ADDR;
								done_q   <= 1'b1;
							end else if (count_q == '0) begin
								status_q <= (off_ext == H_C) ? bfa_pkg::ST_NOT_BUSY
								                             : bfa_pkg::ST_BAD_ADDR;
								done_q   <= 1'b1;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_MAT: begin
					count_q <= CNTW'(1);
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					pend_s1 <= mem_re;
					idx_s1  <= issue_q;
					if (mem_re) begin
						issue_q <= issue_q + CNTW'(1);
					end
					if (pend_s1) begin
						last_q <= mem_rd;
						if (action_q == bfa_pkg::ACT_ALLOC) begin
							if (!rd_busy && (CW'(rd_size) >= need_q) &&
							    (!found_q || (rd_size < best_size_q))) begin
								found_q      <= 1'b1;
								best_idx_q   <= idx_s1;
								best_size_q  <= rd_size;
								best_start_q <= rd_start;
							end
						end else begin
							if (!found_q && (CW'(rd_start) == target_q)) begin
								found_q      <= 1'b1;
								best_idx_q   <= idx_s1;
								best_size_q  <= rd_size;
								best_start_q <= rd_start;
								best_busy_q  <= rd_busy;
								prev_q       <= last_q;
							end
							if (found_q && (idx_s1 == best_idx_q + CNTW'(1))) begin
								next_q   <= mem_rd;
								next_v_q <= 1'b1;
							end
						end
					end
					if (!mem_re && !pend_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					w2_v_q <= 1'b0;
					if (action_q == bfa_pkg::ACT_ALLOC) begin
						if (!found_q) begin
							status_q <= bfa_pkg::ST_NO_FIT;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							status_q  <= bfa_pkg::ST_OK;
							granted_q <= OFFW'(CW'(best_start_q) + H_C);
							w1_v_q    <= 1'b1;
							w1_a_q    <= best_idx_q[IW-1:0];
							sh_up_q   <= 1'b1;
							sh_n_q    <= 2'd1;
							sh_dst_q  <= count_q;
							state_q   <= S_SH_RD;
							if (split) begin
								w1_d_q      <= {1'b1, OB'(rounded_q), best_start_q};
								w2_v_q      <= 1'b1;
								w2_a_q      <= IW'(best_idx_q + CNTW'(1));
								w2_d_q      <= {1'b0, nsize, nstart};
								sh_lim_q    <= best_idx_q + CNTW'(1);
								new_count_q <= count_q + CNTW'(1);
							end else begin
								w1_d_q      <= {1'b1, best_size_q, best_start_q};
								sh_lim_q    <= count_q;
								new_count_q <= count_q;
							end
						end
					end else begin
						if (!found_q) begin
							status_q <= bfa_pkg::ST_BAD_ADDR;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else if (!best_busy_q) begin
							status_q <= bfa_pkg::ST_NOT_BUSY;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							status_q <= bfa_pkg::ST_OK;
							w1_v_q   <= 1'b1;
							sh_up_q  <= 1'b0;
							sh_lim_q <= count_q;
							state_q  <= S_SH_RD;
							if (left_m) begin
								w1_a_q      <= IW'(best_idx_q - CNTW'(1));
								w1_d_q      <= {1'b0, left_sz, prev_q[OB-1:0]};
								sh_dst_q    <= best_idx_q;
								sh_n_q      <= right_m ? 2'd2 : 2'd1;
								new_count_q <= count_q - (right_m ? CNTW'(2) : CNTW'(1));
							end else begin
								w1_a_q      <= best_idx_q[IW-1:0];
								w1_d_q      <= {1'b0, merged, best_start_q};
								sh_dst_q    <= best_idx_q + CNTW'(1);
								sh_n_q      <= right_m ? 2'd1 : 2'd0;
								new_count_q <= count_q - (right_m ? CNTW'(1) : CNTW'(0));
							end
						end
					end
				end
				S_SH_RD: begin
					state_q <= sh_go ? S_SH_WR : S_WR1;
				end
				S_SH_WR: begin
					sh_dst_q <= sh_up_q ? sh_dst_q - CNTW'(1) : sh_dst_q + CNTW'(1);
					state_q  <= S_SH_RD;
				end
				S_WR1: begin
					state_q <= S_WR2;
				end
				S_WR2: begin
					count_q <= new_count_q;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Checks
	a_done_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) != S_IDLE) || $past(start))
		else $error("result strobe without a request in progress");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_C)
		else $error("block count beyond table depth");

	a_grant_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q != bfa_pkg::ST_OK)) |-> (granted_q == '0))
		else $error("offset granted on a failed request");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("table read and write in the same cycle");

endmodule
`default_nettype wire
